### sv/bsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants of the barometric sensor compensation block.
// ----------------------------------------------------------------------------
package bsc_pkg;

   // datapath word, every intermediate wraps at this width
   localparam int DATA_W = 32;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_AC1_AC2 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AC3_AC4 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AC5_AC6 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_B1_B2   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MC_MD   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OSS     = 3'd5;

   localparam logic [1:0] OSS_RESET = 2'd3;

   // compensation constants
   localparam logic [DATA_W-1:0] B6_OFFSET    = 32'd4000;
   localparam logic [DATA_W-1:0] B4_OFFSET    = 32'd32768;
   localparam logic [DATA_W-1:0] B7_SCALE     = 32'd50000;
   localparam logic [DATA_W-1:0] P_COEF_SQ    = 32'd3038;
   localparam logic [DATA_W-1:0] P_COEF_LIN   = 32'hFFFF_E343; // -7357
   localparam logic [DATA_W-1:0] P_COEF_OFS   = 32'd3791;
   localparam logic [DATA_W-1:0] T_MAX        = 32'h0000_7FFF;
   localparam logic [DATA_W-1:0] T_MIN        = 32'hFFFF_8000;
   localparam logic [DATA_W-1:0] P_MAX        = 32'd1048575;

   typedef struct packed {
      logic [15:0] raw_temp;
      logic [18:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic [15:0] temperature_decic;
      logic [19:0] pressure_pa;
      logic        div_fault;
   } rsp_type;

   // beat sideband through the temperature divider
   typedef struct packed {
      logic [DATA_W-1:0] x1;
      logic              neg;
      logic              fault;
      logic [18:0]       up;
   } div1_side_type;

   // beat sideband through the pressure divider
   typedef struct packed {
      logic        fault;
      logic [15:0] temp;
      logic        dbl;
   } div2_side_type;

endpackage

### sv/baro_sensor_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// Integer temperature and pressure compensation for a barometric sensor.
// ----------------------------------------------------------------------------
// A beat is taken on every cycle with start high; busy never rises, and the
// result appears on rsp_data with rsp_valid high for one cycle, in order,
// after two 32-stage pipelined dividers (temperature term and pressure
// quotient) and 13 stages of multiply and adjust logic. The receiver cannot
// stall; a new beat may follow every cycle. Write calibration only with no
// beats in flight. A zero divisor gives div_fault with zero temperature and
// pressure.
// ----------------------------------------------------------------------------
module baro_sensor_compensation (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  bsc_pkg::req_type               req_data,
   output logic                           rsp_valid,
   output bsc_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bsc_pkg::DATA_W-1:0]     csr_data
);

   localparam int W = bsc_pkg::DATA_W;
   localparam int LAT = 2 * W + 13;

   // ---------------- configuration ----------------
   logic [W-1:0] cal_ac1_ac2_ff, cal_ac3_ac4_ff, cal_ac5_ac6_ff, cal_b1_b2_ff, cal_mc_md_ff;
   logic [1:0]   oss_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ac1_ac2_ff <= '0;
         cal_ac3_ac4_ff <= '0;
         cal_ac5_ac6_ff <= '0;
         cal_b1_b2_ff   <= '0;
         cal_mc_md_ff   <= '0;
         oss_ff         <= bsc_pkg::OSS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bsc_pkg::CSR_AC1_AC2: cal_ac1_ac2_ff <= csr_data;
            bsc_pkg::CSR_AC3_AC4: cal_ac3_ac4_ff <= csr_data;
            bsc_pkg::CSR_AC5_AC6: cal_ac5_ac6_ff <= csr_data;
            bsc_pkg::CSR_B1_B2:   cal_b1_b2_ff   <= csr_data;
            bsc_pkg::CSR_MC_MD:   cal_mc_md_ff   <= csr_data;
            bsc_pkg::CSR_OSS:     oss_ff         <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // calibration words, sign extended where signed
   logic [W-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = {{16{cal_ac1_ac2_ff[31]}}, cal_ac1_ac2_ff[31:16]};
   assign ac2 = {{16{cal_ac1_ac2_ff[15]}}, cal_ac1_ac2_ff[15:0]};
   assign ac3 = {{16{cal_ac3_ac4_ff[31]}}, cal_ac3_ac4_ff[31:16]};
   assign ac4 = {16'b0, cal_ac3_ac4_ff[15:0]};
   assign ac5 = {16'b0, cal_ac5_ac6_ff[31:16]};
   assign ac6 = {16'b0, cal_ac5_ac6_ff[15:0]};
   assign b1  = {{16{cal_b1_b2_ff[31]}}, cal_b1_b2_ff[31:16]};
   assign b2  = {{16{cal_b1_b2_ff[15]}}, cal_b1_b2_ff[15:0]};
   assign mc  = {{16{cal_mc_md_ff[31]}}, cal_mc_md_ff[31:16]};
   assign md  = {{16{cal_mc_md_ff[15]}}, cal_mc_md_ff[15:0]};

   logic accept;
   assign accept = start && !busy;

   // ---------------- s1: (ut - ac6) * ac5 ----------------
   logic         v1_ff;
   logic [W-1:0] s1_prod_ff;
   logic [18:0]  s1_up_ff;

   always_ff @(posedge clock) begin
      s1_prod_ff <= ({16'b0, req_data.raw_temp} - ac6) * ac5;
      s1_up_ff   <= req_data.raw_pressure;
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= accept;
   end

   // ---------------- s2: x1, divisor and operand magnitudes ----------------
   logic         v2_ff;
   logic [W-1:0] s2_num_ff, s2_den_ff;
   bsc_pkg::div1_side_type s2_side_ff;
   logic [W-1:0] s2_x1, s2_den, s2_num;

   always_comb begin
      s2_x1  = W'($signed(s1_prod_ff) >>> 15);
      s2_den = s2_x1 + md;
      s2_num = {mc[W-12:0], 11'b0};
   end

   always_ff @(posedge clock) begin
      s2_num_ff        <= s2_num[W-1] ? W'(0 - s2_num) : s2_num;
      s2_den_ff        <= s2_den[W-1] ? W'(0 - s2_den) : s2_den;
      s2_side_ff.x1    <= s2_x1;
      s2_side_ff.neg   <= s2_num[W-1] ^ s2_den[W-1];
      s2_side_ff.fault <= (s2_den == '0);
      s2_side_ff.up    <= s1_up_ff;
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
   end

   // ---------------- temperature divider ----------------
   logic         d1_valid;
   logic [W-1:0] d1_quo;
   bsc_pkg::div1_side_type d1_side;

   bsc_div #(.W(W), .side_type(bsc_pkg::div1_side_type)) u_div_temp (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (v2_ff),
      .in_dividend  (s2_num_ff),
      .in_divisor   (s2_den_ff),
      .in_side      (s2_side_ff),
      .out_valid    (d1_valid),
      .out_quotient (d1_quo),
      .out_side     (d1_side)
   );

   // ---------------- s3: b5, temperature, b6 ----------------
   logic         v3_ff, s3_fault_ff;
   logic [W-1:0] s3_b6_ff;
   logic [15:0]  s3_temp_ff;
   logic [18:0]  s3_up_ff;
   logic [W-1:0] s3_b5, s3_t;

   always_comb begin
      s3_b5 = d1_side.x1 + (d1_side.neg ? W'(0 - d1_quo) : d1_quo);
      s3_t  = W'($signed(W'(s3_b5 + W'(8))) >>> 4);
   end

   always_ff @(posedge clock) begin
      s3_b6_ff    <= s3_b5 - bsc_pkg::B6_OFFSET;
      if ($signed(s3_t) > $signed(bsc_pkg::T_MAX))      s3_temp_ff <= bsc_pkg::T_MAX[15:0];
      else if ($signed(s3_t) < $signed(bsc_pkg::T_MIN)) s3_temp_ff <= bsc_pkg::T_MIN[15:0];
      else                                              s3_temp_ff <= s3_t[15:0];
      s3_fault_ff <= d1_side.fault;
      s3_up_ff    <= d1_side.up;
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= d1_valid;
   end

   // ---------------- s4: products of b6 ----------------
   logic         v4_ff, s4_fault_ff;
   logic [W-1:0] s4_sq_ff, s4_a2_ff, s4_a3_ff;
   logic [15:0]  s4_temp_ff;
   logic [18:0]  s4_up_ff;

   always_ff @(posedge clock) begin
      s4_sq_ff    <= s3_b6_ff * s3_b6_ff;
      s4_a2_ff    <= ac2 * s3_b6_ff;
      s4_a3_ff    <= ac3 * s3_b6_ff;
      s4_fault_ff <= s3_fault_ff;
      s4_temp_ff  <= s3_temp_ff;
      s4_up_ff    <= s3_up_ff;
      if (reset) v4_ff <= 1'b0;
      else       v4_ff <= v3_ff;
   end

   // ---------------- s5: scale the products ----------------
   logic         v5_ff, s5_fault_ff;
   logic [W-1:0] s5_sq_ff, s5_x2a_ff, s5_x1c_ff;
   logic [15:0]  s5_temp_ff;
   logic [18:0]  s5_up_ff;

   always_ff @(posedge clock) begin
      s5_sq_ff    <= W'($signed(s4_sq_ff) >>> 12);
      s5_x2a_ff   <= W'($signed(s4_a2_ff) >>> 11);
      s5_x1c_ff   <= W'($signed(s4_a3_ff) >>> 13);
      s5_fault_ff <= s4_fault_ff;
      s5_temp_ff  <= s4_temp_ff;
      s5_up_ff    <= s4_up_ff;
      if (reset) v5_ff <= 1'b0;
      else       v5_ff <= v4_ff;
   end

   // ---------------- s6: b2 * sq, b1 * sq ----------------
   logic         v6_ff, s6_fault_ff;
   logic [W-1:0] s6_b2p_ff, s6_b1p_ff, s6_x2a_ff, s6_x1c_ff;
   logic [15:0]  s6_temp_ff;
   logic [18:0]  s6_up_ff;

   always_ff @(posedge clock) begin
      s6_b2p_ff   <= b2 * s5_sq_ff;
      s6_b1p_ff   <= b1 * s5_sq_ff;
      s6_x2a_ff   <= s5_x2a_ff;
      s6_x1c_ff   <= s5_x1c_ff;
      s6_fault_ff <= s5_fault_ff;
      s6_temp_ff  <= s5_temp_ff;
      s6_up_ff    <= s5_up_ff;
      if (reset) v6_ff <= 1'b0;
      else       v6_ff <= v5_ff;
   end

   // ---------------- s7: b3 and the b4 term ----------------
   logic         v7_ff, s7_fault_ff;
   logic [W-1:0] s7_b3_ff, s7_x3_ff;
   logic [15:0]  s7_temp_ff;
   logic [18:0]  s7_up_ff;
   logic [W-1:0] s7_x3a, s7_b3s, s7_x3b;

   always_comb begin
      s7_x3a = W'($signed(s6_b2p_ff) >>> 11) + s6_x2a_ff;
      s7_b3s = W'(({ac1[W-3:0], 2'b0} + s7_x3a) << oss_ff) + W'(2);
      s7_x3b = W'($signed(s6_b1p_ff) >>> 16) + s6_x1c_ff + W'(2);
   end

   always_ff @(posedge clock) begin
      s7_b3_ff    <= W'($signed(s7_b3s) >>> 2);
      s7_x3_ff    <= W'($signed(s7_x3b) >>> 2);
      s7_fault_ff <= s6_fault_ff;
      s7_temp_ff  <= s6_temp_ff;
      s7_up_ff    <= s6_up_ff;
      if (reset) v7_ff <= 1'b0;
      else       v7_ff <= v6_ff;
   end

   // ---------------- s8: ac4 product, up - b3 ----------------
   logic         v8_ff, s8_fault_ff;
   logic [W-1:0] s8_b4p_ff, s8_upmb_ff;
   logic [15:0]  s8_temp_ff;

   always_ff @(posedge clock) begin
      s8_b4p_ff   <= ac4 * (s7_x3_ff + bsc_pkg::B4_OFFSET);
      s8_upmb_ff  <= {13'b0, s7_up_ff} - s7_b3_ff;
      s8_fault_ff <= s7_fault_ff;
      s8_temp_ff  <= s7_temp_ff;
      if (reset) v8_ff <= 1'b0;
      else       v8_ff <= v7_ff;
   end

   // ---------------- s9: b4, b7 ----------------
   logic         v9_ff, s9_fault_ff;
   logic [W-1:0] s9_b4_ff, s9_b7_ff;
   logic [15:0]  s9_temp_ff;

   always_ff @(posedge clock) begin
      s9_b4_ff    <= s8_b4p_ff >> 15;
      s9_b7_ff    <= s8_upmb_ff * (bsc_pkg::B7_SCALE >> oss_ff);
      s9_fault_ff <= s8_fault_ff;
      s9_temp_ff  <= s8_temp_ff;
      if (reset) v9_ff <= 1'b0;
      else       v9_ff <= v8_ff;
   end

   // ---------------- s10: pressure divider operands ----------------
   logic         v10_ff;
   logic [W-1:0] s10_num_ff, s10_den_ff;
   bsc_pkg::div2_side_type s10_side_ff;

   always_ff @(posedge clock) begin
      // large b7 divides first and doubles after, small b7 doubles first
      s10_num_ff        <= s9_b7_ff[W-1] ? s9_b7_ff : {s9_b7_ff[W-2:0], 1'b0};
      s10_den_ff        <= s9_b4_ff;
      s10_side_ff.fault <= s9_fault_ff || (s9_b4_ff == '0);
      s10_side_ff.temp  <= s9_temp_ff;
      s10_side_ff.dbl   <= s9_b7_ff[W-1];
      if (reset) v10_ff <= 1'b0;
      else       v10_ff <= v9_ff;
   end

   // ---------------- pressure divider ----------------
   logic         d2_valid;
   logic [W-1:0] d2_quo;
   bsc_pkg::div2_side_type d2_side;

   bsc_div #(.W(W), .side_type(bsc_pkg::div2_side_type)) u_div_pres (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (v10_ff),
      .in_dividend  (s10_num_ff),
      .in_divisor   (s10_den_ff),
      .in_side      (s10_side_ff),
      .out_valid    (d2_valid),
      .out_quotient (d2_quo),
      .out_side     (d2_side)
   );

   // ---------------- s11: p, square and linear terms ----------------
   logic         v11_ff, s11_fault_ff;
   logic [W-1:0] s11_p_ff, s11_sq_ff, s11_lin_ff;
   logic [15:0]  s11_temp_ff;
   logic [W-1:0] s11_p, s11_pp;

   always_comb begin
      s11_p  = d2_side.dbl ? {d2_quo[W-2:0], 1'b0} : d2_quo;
      s11_pp = W'($signed(s11_p) >>> 8);
   end

   always_ff @(posedge clock) begin
      s11_p_ff     <= s11_p;
      s11_sq_ff    <= s11_pp * s11_pp;
      s11_lin_ff   <= bsc_pkg::P_COEF_LIN * s11_p;
      s11_fault_ff <= d2_side.fault;
      s11_temp_ff  <= d2_side.temp;
      if (reset) v11_ff <= 1'b0;
      else       v11_ff <= d2_valid;
   end

   // ---------------- s12: weight the square term ----------------
   logic         v12_ff, s12_fault_ff;
   logic [W-1:0] s12_p_ff, s12_sq_ff, s12_x2_ff;
   logic [15:0]  s12_temp_ff;

   always_ff @(posedge clock) begin
      s12_p_ff     <= s11_p_ff;
      s12_sq_ff    <= s11_sq_ff * bsc_pkg::P_COEF_SQ;
      s12_x2_ff    <= W'($signed(s11_lin_ff) >>> 16);
      s12_fault_ff <= s11_fault_ff;
      s12_temp_ff  <= s11_temp_ff;
      if (reset) v12_ff <= 1'b0;
      else       v12_ff <= v11_ff;
   end

   // ---------------- s13: final correction, saturation, output ----------------
   logic         rsp_valid_ff;
   bsc_pkg::rsp_type rsp_data_ff;
   logic [W-1:0] s13_sum, s13_p;

   always_comb begin
      s13_sum = W'($signed(s12_sq_ff) >>> 16) + s12_x2_ff + bsc_pkg::P_COEF_OFS;
      s13_p   = s12_p_ff + W'($signed(s13_sum) >>> 4);
   end

   always_ff @(posedge clock) begin
      if (s12_fault_ff) begin
         rsp_data_ff.temperature_decic <= '0;
         rsp_data_ff.pressure_pa       <= '0;
      end else begin
         rsp_data_ff.temperature_decic <= s12_temp_ff;
         if (s13_p[W-1])
            rsp_data_ff.pressure_pa <= '0;
         else if (s13_p > bsc_pkg::P_MAX)
            rsp_data_ff.pressure_pa <= bsc_pkg::P_MAX[19:0];
         else
            rsp_data_ff.pressure_pa <= s13_p[19:0];
      end
      rsp_data_ff.div_fault <= s12_fault_ff;
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= v12_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // every result answers an earlier accepted request beat
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("result without matching request beat");

   // a faulted result carries zero fields
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.div_fault) |->
         (rsp_data.temperature_decic == '0 && rsp_data.pressure_pa == '0))
      else $error("faulted result with nonzero fields");

   // a zero temperature divisor always shows up as a fault at the output
   a_den_fault: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && s2_den == '0) |-> ##(LAT-1) (rsp_valid && rsp_data.div_fault))
      else $error("zero divisor not flagged");

endmodule

### sv/bsc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_div
// Pipelined restoring unsigned divider, one quotient bit per stage, with a
// sideband beat that travels alongside. It takes one beat per cycle.
// ----------------------------------------------------------------------------
module bsc_div #(
   parameter int  W = bsc_pkg::DATA_W,
   parameter type side_type = logic
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic [W-1:0] in_dividend,
   input  logic [W-1:0] in_divisor,
   input  side_type     in_side,
   output logic         out_valid,
   output logic [W-1:0] out_quotient,
   output side_type     out_side
);

   logic [W-1:0] rem_ff [W];
   logic [W-1:0] num_ff [W];
   logic [W-1:0] quo_ff [W];
   logic [W-1:0] dvs_ff [W];
   side_type     side_ff [W];
   logic [W-1:0] vld_ff;

   logic [W-1:0] rem_in [W];
   logic [W-1:0] num_in [W];
   logic [W-1:0] quo_in [W];
   logic [W-1:0] dvs_in [W];
   side_type     side_in [W];
   logic [W-1:0] vld_in;

   // one shift-compare-subtract step per stage
   always_comb begin
      logic [W-1:0] rp, np, qp, dp;
      logic [W:0]   trial;
      logic         ge;
      for (int k = 0; k < W; k++) begin
         if (k == 0) begin
            rp = '0;
            np = in_dividend;
            qp = '0;
            dp = in_divisor;
            side_in[k] = in_side;
            vld_in[k] = in_valid;
         end else begin
            rp = rem_ff[k-1];
            np = num_ff[k-1];
            qp = quo_ff[k-1];
            dp = dvs_ff[k-1];
            side_in[k] = side_ff[k-1];
            vld_in[k] = vld_ff[k-1];
         end
         trial = {rp, np[W-1]};
         ge = (trial >= {1'b0, dp});
         rem_in[k] = ge ? W'(trial - {1'b0, dp}) : trial[W-1:0];
         num_in[k] = {np[W-2:0], 1'b0};
         quo_in[k] = {qp[W-2:0], ge};
         dvs_in[k] = dp;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < W; k++) begin
         rem_ff[k]  <= rem_in[k];
         num_ff[k]  <= num_in[k];
         quo_ff[k]  <= quo_in[k];
         dvs_ff[k]  <= dvs_in[k];
         side_ff[k] <= side_in[k];
      end
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign out_valid    = vld_ff[W-1];
   assign out_quotient = quo_ff[W-1];
   assign out_side     = side_ff[W-1];

   // remainder left after the last step is below a nonzero divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[W-1] && dvs_ff[W-1] != '0) |-> (rem_ff[W-1] < dvs_ff[W-1]))
      else $error("divider remainder not below divisor");

   // every beat that leaves matches an earlier entry
   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> $past(in_valid, W))
      else $error("divider beat without matching entry");

endmodule
